// ===== rtl/core/edacc_pkg.sv =====
// Shared types and constants for the Euclidean distance accumulator.
package edacc_pkg;

  // Input sample width and the derived difference magnitude width.
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SQ_W     = 2 * MAG_W;

  // Running sum and root widths.
  localparam int SUM_W  = 44;
  localparam int ROOT_W = SUM_W / 2;

  // Default longest vector before the sum saturates.
  localparam int MAX_DIM_DEF = 4096;

  // Depth of the queue between accumulator and root unit.
  localparam int QUEUE_DEPTH = 2;

  // One input request: a pair of matching vector elements.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_element;
    logic signed [SAMPLE_W-1:0] second_element;
    logic                       last_element;
  } edacc_in_t;

  // One result: the distance and the overflow flag.
  typedef struct packed {
    logic [ROOT_W-1:0] distance_value;
    logic              overflowed;
  } edacc_out_t;

  // A finished vector sum handed from the front to the root unit.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             overflowed;
  } edacc_sum_t;

endpackage

// ===== rtl/core/edacc_front.sv =====
// Front end: difference, square and saturating accumulation of element pairs.
module edacc_front
  import edacc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  edacc_in_t  in_req,
  output logic       push_valid,
  input  logic       push_ready,
  output edacc_sum_t push_data
);

  localparam int CNT_W = $clog2(MAX_DIM + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM);
  localparam logic [CNT_W-1:0] CNT_OVF = CNT_W'(MAX_DIM + 1);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  logic             s1_valid_r;
  logic             s1_last_r;
  logic [MAG_W-1:0] mag_r;
  logic             s2_valid_r;
  logic             s2_last_r;
  logic [SUM_W-1:0] sq_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [SQ_W-1:0]         sq;
  logic [SUM_W:0]          sum_add;
  logic [CNT_W-1:0]        cnt_inc;
  logic [SUM_W-1:0]        sum_acc;
  logic [CNT_W-1:0]        cnt_acc;
  logic                    advance;

  // The pipeline stalls only when a finished vector cannot enter the queue.
  assign advance  = !(s2_valid_r && s2_last_r && !push_ready);
  assign in_ready = advance;

  // Stage one: signed difference and its magnitude.
  always_comb begin
    diff = $signed({in_req.first_element[SAMPLE_W-1], in_req.first_element})
         - $signed({in_req.second_element[SAMPLE_W-1], in_req.second_element});
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  // Stage two: the square, which always fits below the sum width.
  assign sq = mag_r * mag_r;

  // Stage three: count, saturating add and end-of-vector handling.
  always_comb begin
    cnt_inc = (cnt_r <= CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    sum_add = {1'b0, sum_r} + {1'b0, sq_r};
    if (cnt_inc > CNT_MAX) begin
      sum_acc = SUM_MAX;
      cnt_acc = cnt_inc;
    end else if (sum_add[SUM_W]) begin
      sum_acc = SUM_MAX;
      cnt_acc = CNT_OVF;
    end else begin
      sum_acc = sum_add[SUM_W-1:0];
      cnt_acc = cnt_inc;
    end

    push_valid           = s2_valid_r && s2_last_r;
    push_data.sum        = sum_acc;
    push_data.overflowed = (cnt_acc > CNT_MAX);

    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (s2_valid_r && advance) begin
      if (s2_last_r) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_acc;
        cnt_nxt = cnt_acc;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      sum_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (advance) begin
        s1_valid_r <= in_valid;
        s2_valid_r <= s1_valid_r;
      end
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      mag_r     <= mag;
      s1_last_r <= in_req.last_element;
      sq_r      <= SUM_W'(sq);
      s2_last_r <= s1_last_r;
    end
  end

  // The count never passes the overflow mark.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_OVF)
    else $error("element count beyond overflow mark");

  // Once overflowed, the sum stays saturated until the vector ends.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_OVF |-> sum_r == SUM_MAX)
    else $error("overflowed vector without saturated sum");

  // A finished vector is held at the queue until taken.
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_ready |=> push_valid && $stable(push_data))
    else $error("finished vector dropped while queue full");

endmodule

// ===== rtl/core/edacc_fifo.sv =====
// Small register queue carrying finished sums from the front to the root unit.
module edacc_fifo
  import edacc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  edacc_sum_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output edacc_sum_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  edacc_sum_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // The fill count stays within the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/core/edacc_sqrt.sv =====
// Back end: bit-serial integer square root and the result register.
module edacc_sqrt
  import edacc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  edacc_sum_t pop_data,
  output logic       out_valid,
  input  logic       out_ready,
  output edacc_out_t out_res
);

  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  value_r, value_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  edacc_out_t        out_res_r, out_res_nxt;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              load_out;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign pop_ready = (state_r == ST_IDLE);
  assign load_out  = (state_r == ST_WAIT) && (!out_valid_r || out_ready);

  // One root bit per cycle: bring down two bits and try to subtract.
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], value_r[SUM_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    value_nxt     = value_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    // The result register empties when the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          value_nxt = pop_data.sum;
          ovf_nxt   = pop_data.overflowed;
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        value_nxt = {value_r[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (load_out) begin
          out_valid_nxt              = 1'b1;
          out_res_nxt.distance_value = root_r;
          out_res_nxt.overflowed     = ovf_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    value_r   <= value_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    ovf_r     <= ovf_nxt;
    out_res_r <= out_res_nxt;
  end

  // The partial remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> rem_r <= REM_W'({root_r, 1'b0}))
    else $error("square root remainder out of range");

  // A saturated vector always reads as the largest distance.
  a_ovf_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.overflowed |-> out_res_r.distance_value == {ROOT_W{1'b1}})
    else $error("overflowed result without full-scale distance");

  // A new sum is taken only when the unit is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> state_r == ST_RUN && step_r == '0)
    else $error("root unit did not start on a new sum");

endmodule

// ===== rtl/core/euclidean_distance_accumulator.sv =====
// Top level of the Euclidean distance accumulator.
//
// Usage: each input request on in_valid/in_ready carries one pair of signed
// 16-bit elements and a last flag. The front squares the element difference
// and adds it to a 44-bit running sum. The request marked last closes the
// vector: its sum goes into a two-entry queue and the sum is cleared.
// The back takes sums from the queue and computes the floor square root one
// bit per cycle; each result request on out_valid/out_ready carries the
// distance and an overflow flag. Vectors longer than MAX_DIM saturate the
// sum and report overflow with the full-scale distance.
// Throughput: one element pair per cycle inside a vector while the queue can
// take finished sums. The root unit loads a sum, iterates once per root bit
// and hands off the result before it takes the next, so short vectors are
// limited by the root unit.
// Reset clears the pipeline, the sum, the count, the queue and the result
// register. When the receiver stalls, the result register holds, the root
// unit waits, the queue fills, and then in_ready drops on a last element.
module euclidean_distance_accumulator
  import edacc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  edacc_in_t  in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output edacc_out_t out_res
);

  logic       push_valid, push_ready;
  edacc_sum_t push_data;
  logic       pop_valid, pop_ready;
  edacc_sum_t pop_data;

  // Accumulating front end.
  edacc_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue of finished sums.
  edacc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Square root back end.
  edacc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Euclidean distance accumulator.
`timescale 1ns / 1ps

module tb_top;
  import edacc_pkg::*;

  localparam longint unsigned SUM_CAP   = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned WIDE_DIFF = 64'd1 << ROOT_W;
  localparam int IDLE_PCT      = 34;
  localparam int STALL_CYCLES  = 500;
  localparam int STALL_AFTER   = 25;
  localparam int DRAIN_CYCLES  = 40;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int RANDOM_PAIRS  = 800;
  localparam int REPORT_MAX    = 10;

  // How the elements of one random vector are chosen.
  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_EDGE,
    FILL_EQUAL,
    FILL_MAXDIFF
  } fill_style_t;

  // A pending request plus a flag that turns off idling while it is in flight.
  typedef struct {
    edacc_in_t req;
    bit        steady;
  } pair_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  edacc_in_t  in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  edacc_out_t out_res;

  pair_item_t pending_pairs[$];
  pair_item_t next_pair;
  edacc_out_t distances_due[$];
  edacc_out_t due_now;
  edacc_out_t predicted;

  // Predictor state: the running sum of squares and the element count.
  longint unsigned dist_sum = 0;
  int unsigned     pair_count = 0;

  bit rx_calm = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;
  int results_seen = 0;
  int failures = 0;
  int idle_cycles = 0;

  euclidean_distance_accumulator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  always #1 clk = ~clk;

  // Floor square root, built one result bit at a time from the top.
  function automatic logic [ROOT_W-1:0] floor_sqrt(input longint unsigned x);
    logic [ROOT_W-1:0] root;
    longint unsigned   trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= x) begin
        root = trial[ROOT_W-1:0];
      end
    end
    return root;
  endfunction

  // Fold one element pair into the sum; returns 1 when a distance is due.
  function automatic bit fold_pair(input edacc_in_t req, output edacc_out_t res);
    int              diff;
    longint unsigned mag;
    longint unsigned sq;
    diff = int'($signed(req.first_element)) - int'($signed(req.second_element));
    mag = longint'((diff < 0) ? -diff : diff);
    res = '0;
    if (pair_count <= MAX_DIM_DEF) begin
      pair_count++;
    end
    // Too many elements forces the sum to full scale; so do wide terms.
    if (pair_count > MAX_DIM_DEF) begin
      dist_sum = SUM_CAP;
    end else if (mag >= WIDE_DIFF) begin
      dist_sum = SUM_CAP;
      pair_count = MAX_DIM_DEF + 1;
    end else begin
      sq = mag * mag;
      if (sq > SUM_CAP - dist_sum) begin
        dist_sum = SUM_CAP;
        pair_count = MAX_DIM_DEF + 1;
      end else begin
        dist_sum += sq;
      end
    end
    if (!req.last_element) begin
      return 1'b0;
    end
    res.distance_value = floor_sqrt(dist_sum);
    res.overflowed = (pair_count > MAX_DIM_DEF);
    dist_sum = 0;
    pair_count = 0;
    return 1'b1;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  task automatic add_pair(input int first, input int second, input bit last,
                          input bit steady);
    pair_item_t item;
    item.req.first_element  = 16'(first);
    item.req.second_element = 16'(second);
    item.req.last_element   = last;
    item.steady = steady;
    pending_pairs.push_back(item);
  endtask

  function automatic int edge_value();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int any_value();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Queue one vector of the given length with elements of the given style.
  task automatic add_vector(input int len, input fill_style_t style, input bit steady);
    int a;
    int b;
    for (int i = 0; i < len; i++) begin
      case (style)
        FILL_SMALL: begin
          a = int'($urandom_range(0, 16)) - 8;
          b = int'($urandom_range(0, 16)) - 8;
        end
        FILL_EDGE: begin
          a = edge_value();
          b = edge_value();
        end
        FILL_EQUAL: begin
          a = any_value();
          b = a;
        end
        FILL_MAXDIFF: begin
          a = $urandom_range(0, 1) ? 32767 : -32768;
          b = (a == 32767) ? -32768 : 32767;
        end
        default: begin
          a = any_value();
          b = any_value();
        end
      endcase
      add_pair(a, b, i == len - 1, steady);
    end
  endtask

  // Sender: offers queued requests, predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else begin
      if (in_valid && in_ready) begin
        if (fold_pair(in_req, predicted)) begin
          distances_due.push_back(predicted);
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_pairs.size() != 0 &&
            (pending_pairs[0].steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_pair = pending_pairs.pop_front();
          in_req <= next_pair.req;
          in_valid <= 1'b1;
          rx_calm <= next_pair.steady;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off to fill the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && results_seen >= STALL_AFTER) begin
      out_ready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= rx_calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: every accepted result must match the oldest predicted distance.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (distances_due.size() == 0) begin
        note_failure($sformatf("unexpected result dist=%0d ovf=%0b",
                               out_res.distance_value, out_res.overflowed));
      end else begin
        due_now = distances_due.pop_front();
        if (out_res.distance_value !== due_now.distance_value) begin
          note_failure($sformatf("distance expected %0d got %0d",
                                 due_now.distance_value, out_res.distance_value));
        end
        if (out_res.overflowed !== due_now.overflowed) begin
          note_failure($sformatf("overflow expected %0b got %0b",
                                 due_now.overflowed, out_res.overflowed));
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
        $display("timeout: no request moved for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int random_pairs;
    int vec_idx;
    int len;
    int pick;
    fill_style_t style;

    // Single-element vectors at the extremes of the range.
    add_pair(0, 0, 1'b1, 1'b0);
    add_pair(32767, -32768, 1'b1, 1'b0);
    add_pair(-32768, 32767, 1'b1, 1'b0);
    add_pair(-32768, -32768, 1'b1, 1'b0);
    add_pair(32767, 32767, 1'b1, 1'b0);
    // Short vectors: exact root, truncated root, and a sum of two.
    add_pair(3, 0, 1'b0, 1'b0);
    add_pair(0, -4, 1'b1, 1'b0);
    add_pair(2, 0, 1'b0, 1'b0);
    add_pair(0, 2, 1'b0, 1'b0);
    add_pair(-4, 0, 1'b1, 1'b0);
    add_pair(-1, 0, 1'b0, 1'b0);
    add_pair(0, -1, 1'b1, 1'b0);
    add_vector(4, FILL_MAXDIFF, 1'b0);
    // A longer vector at full-scale differences gives a large sum.
    add_vector(40, FILL_MAXDIFF, 1'b0);
    // The sum and the count must be cleared after a large vector.
    add_pair(5, -7, 1'b1, 1'b0);

    // Random vectors: mostly short, some medium, a few long.
    random_pairs = 0;
    vec_idx = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 6);
      end else if (pick < 97) begin
        len = $urandom_range(7, 40);
      end else begin
        len = $urandom_range(100, 200);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        style = FILL_FULL;
      end else if (pick < 6) begin
        style = FILL_SMALL;
      end else if (pick < 8) begin
        style = FILL_EDGE;
      end else if (pick < 9) begin
        style = FILL_EQUAL;
      end else begin
        style = FILL_MAXDIFF;
      end
      // A block of vectors runs with no idling on either side.
      add_vector(len, style, vec_idx >= 20 && vec_idx < 36);
      random_pairs += len;
      vec_idx++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (distances_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
